@@ rtl/bdm_pkg.sv @@
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and constants for the best Distance-IoU box match block.
// ----------------------------------------------------------------------------
package bdm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEOM,
        ST_PROD,
        ST_SUMS,
        ST_IOU_START,
        ST_IOU_WAIT,
        ST_DIST_START,
        ST_DIST_WAIT,
        ST_UPDATE,
        ST_EMIT
    } bdm_state_t;

    typedef enum logic {
        DIV_IOU,
        DIV_DIST
    } div_sel_t;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_REF_X = 2'd0;
    localparam logic [1:0] REG_REF_Y = 2'd1;
    localparam logic [1:0] REG_REF_W = 2'd2;
    localparam logic [1:0] REG_REF_H = 2'd3;

    typedef struct packed {
        logic     load;
        logic     geom;
        logic     prod;
        logic     sums;
        logic     div_start;
        div_sel_t div_sel;
        logic     iou_latch;
        logic     update;
        logic     emit;
    } bdm_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
        logic last;
    } bdm_status_t;

endpackage

@@ rtl/bdm_div.sv @@
// ----------------------------------------------------------------------------
// bdm_div
// Restoring divider that produces one quotient bit per cycle, high bit first.
// ----------------------------------------------------------------------------
module bdm_div
    import bdm_pkg::*;
#(
    parameter int unsigned DEN_W = 31,
    parameter int unsigned Q_W   = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DEN_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [Q_W-1:0]   quo
);

    localparam int unsigned CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             rem_ge;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_ge  = rem_reg >= {1'b0, den_reg};
        rem_sub = rem_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        if (start) begin
            rem_next  = {1'b0, num};
            quo_next  = '0;
            cnt_next  = CNT_LAST;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = {rem_sub[DEN_W-1:0], 1'b0};
            quo_next  = {quo_reg[Q_W-2:0], rem_ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != '0);
        end else begin
            rem_next  = rem_reg;
            quo_next  = quo_reg;
            cnt_next  = cnt_reg;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/bdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdm_ctrl
// Sequencer that steps one candidate through geometry, products, sums and the
// two divisions, then updates the kept box and emits it at frame end.
// ----------------------------------------------------------------------------
module bdm_ctrl
    import bdm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bdm_status_t status,
    output bdm_cmd_t    cmd
);

    bdm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_GEOM;
                end
            end
            ST_GEOM:       state_next = ST_PROD;
            ST_PROD:       state_next = ST_SUMS;
            ST_SUMS:       state_next = ST_IOU_START;
            ST_IOU_START:  state_next = ST_IOU_WAIT;
            ST_IOU_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_DIST_START;
                end
            end
            ST_DIST_START: state_next = ST_DIST_WAIT;
            ST_DIST_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_GEOM:  cmd.geom = 1'b1;
            ST_PROD:  cmd.prod = 1'b1;
            ST_SUMS:  cmd.sums = 1'b1;
            ST_IOU_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_IOU;
            end
            ST_IOU_WAIT: begin
                cmd.iou_latch = !status.div_busy;
            end
            ST_DIST_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DIST;
            end
            ST_DIST_WAIT: begin
            end
            ST_UPDATE: cmd.update = 1'b1;
            ST_EMIT:   cmd.emit   = status.out_free;
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/bdm_datapath.sv @@
// ----------------------------------------------------------------------------
// bdm_datapath
// Box geometry, squared terms, the shared divider, the kept best box and the
// result register.
// ----------------------------------------------------------------------------
module bdm_datapath
    import bdm_pkg::*;
#(
    parameter int unsigned COORD_BITS = 13,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdm_cmd_t                       cmd,
    output bdm_status_t                    status,
    input  logic signed [COORD_BITS-1:0]   s_cand_x,
    input  logic signed [COORD_BITS-1:0]   s_cand_y,
    input  logic        [COORD_BITS-2:0]   s_cand_w,
    input  logic        [COORD_BITS-2:0]   s_cand_h,
    input  logic                           s_last_cand,
    input  logic signed [COORD_BITS-1:0]   ref_x,
    input  logic signed [COORD_BITS-1:0]   ref_y,
    input  logic        [COORD_BITS-2:0]   ref_w,
    input  logic        [COORD_BITS-2:0]   ref_h,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic signed [COORD_BITS-1:0]   m_best_x,
    output logic signed [COORD_BITS-1:0]   m_best_y,
    output logic        [COORD_BITS-2:0]   m_best_w,
    output logic        [COORD_BITS-2:0]   m_best_h,
    output logic signed [FRAC_BITS+1:0]    m_best_score
);

    localparam int unsigned C_W   = COORD_BITS;
    localparam int unsigned S_W   = COORD_BITS - 1;
    localparam int unsigned G_W   = COORD_BITS + 3;
    localparam int unsigned E_W   = COORD_BITS + 1;
    localparam int unsigned D_W   = COORD_BITS + 2;
    localparam int unsigned A_W   = 2 * S_W;
    localparam int unsigned U_W   = A_W + 1;
    localparam int unsigned SQE_W = 2 * E_W;
    localparam int unsigned SQD_W = 2 * D_W;
    localparam int unsigned DEN_W = SQE_W + 3;
    localparam int unsigned Q_W   = FRAC_BITS + 1;
    localparam int unsigned SC_W  = FRAC_BITS + 2;
    localparam logic signed [SC_W-1:0] MINUS_ONE = {2'b11, {FRAC_BITS{1'b0}}};

    logic signed [C_W-1:0] cand_x_reg, cand_y_reg;
    logic        [S_W-1:0] cand_w_reg, cand_h_reg;
    logic                  last_reg;

    logic signed [G_W-1:0] gx, gy, gw, gh, grx, gry, grw, grh;
    logic signed [G_W-1:0] r1, b1, r2, b2;
    logic signed [G_W-1:0] iw, ih, ew, eh, dx, dy, adx, ady;
    logic                  overlap;

    logic [S_W-1:0] iw_reg, ih_reg;
    logic [E_W-1:0] ew_reg, eh_reg;
    logic [D_W-1:0] adx_reg, ady_reg;

    logic [A_W-1:0]   area_c_reg, area_r_reg, inter_reg;
    logic [SQE_W-1:0] ew2_reg, eh2_reg;
    logic [SQD_W-1:0] dx2_reg, dy2_reg;

    logic [U_W-1:0]   uni_next, uni_reg;
    logic [DEN_W-1:0] c4_next, c4_reg, d4_next, d4_reg;
    logic [A_W-1:0]   inter_sum_reg;
    logic             uni_zero_reg;

    logic [DEN_W-1:0] div_num, div_den;
    logic             div_busy;
    logic [Q_W-1:0]   div_quo;
    logic [Q_W-1:0]   iou_q_reg;

    logic signed [SC_W-1:0] score;
    logic                   take;

    logic signed [SC_W-1:0] kept_score_reg;
    logic signed [C_W-1:0]  kept_x_reg, kept_y_reg;
    logic        [S_W-1:0]  kept_w_reg, kept_h_reg;
    logic                   kept_valid_reg;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg;
    logic signed [C_W-1:0]  m_best_x_reg, m_best_y_reg;
    logic        [S_W-1:0]  m_best_w_reg, m_best_h_reg;
    logic signed [SC_W-1:0] m_best_score_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_x_reg <= s_cand_x;
            cand_y_reg <= s_cand_y;
            cand_w_reg <= s_cand_w;
            cand_h_reg <= s_cand_h;
            last_reg   <= s_last_cand;
        end
    end

    always_comb begin
        gx  = G_W'(cand_x_reg);
        gy  = G_W'(cand_y_reg);
        gw  = $signed(G_W'(cand_w_reg));
        gh  = $signed(G_W'(cand_h_reg));
        grx = G_W'(ref_x);
        gry = G_W'(ref_y);
        grw = $signed(G_W'(ref_w));
        grh = $signed(G_W'(ref_h));
        r1  = gx + gw;
        b1  = gy + gh;
        r2  = grx + grw;
        b2  = gry + grh;
        iw  = ((r1 < r2) ? r1 : r2) - ((gx > grx) ? gx : grx);
        ih  = ((b1 < b2) ? b1 : b2) - ((gy > gry) ? gy : gry);
        ew  = ((r1 > r2) ? r1 : r2) - ((gx < grx) ? gx : grx);
        eh  = ((b1 > b2) ? b1 : b2) - ((gy < gry) ? gy : gry);
        dx  = ((gx <<< 1) + gw) - ((grx <<< 1) + grw);
        dy  = ((gy <<< 1) + gh) - ((gry <<< 1) + grh);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        overlap = (iw > 0) && (ih > 0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.geom) begin
            iw_reg  <= overlap ? iw[S_W-1:0] : '0;
            ih_reg  <= overlap ? ih[S_W-1:0] : '0;
            ew_reg  <= ew[E_W-1:0];
            eh_reg  <= eh[E_W-1:0];
            adx_reg <= adx[D_W-1:0];
            ady_reg <= ady[D_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            area_c_reg <= A_W'(cand_w_reg) * A_W'(cand_h_reg);
            area_r_reg <= A_W'(ref_w) * A_W'(ref_h);
            inter_reg  <= A_W'(iw_reg) * A_W'(ih_reg);
            ew2_reg    <= SQE_W'(ew_reg) * SQE_W'(ew_reg);
            eh2_reg    <= SQE_W'(eh_reg) * SQE_W'(eh_reg);
            dx2_reg    <= SQD_W'(adx_reg) * SQD_W'(adx_reg);
            dy2_reg    <= SQD_W'(ady_reg) * SQD_W'(ady_reg);
        end
    end

    always_comb begin
        uni_next = U_W'(area_c_reg) + U_W'(area_r_reg) - U_W'(inter_reg);
        c4_next  = (DEN_W'(ew2_reg) + DEN_W'(eh2_reg)) << 2;
        d4_next  = DEN_W'(dx2_reg) + DEN_W'(dy2_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.sums) begin
            uni_reg       <= uni_next;
            c4_reg        <= c4_next;
            d4_reg        <= d4_next;
            inter_sum_reg <= inter_reg;
            uni_zero_reg  <= (uni_next == '0);
        end
    end

    always_comb begin
        case (cmd.div_sel)
            DIV_IOU: begin
                div_num = DEN_W'(inter_sum_reg);
                div_den = DEN_W'(uni_reg);
            end
            default: begin
                div_num = d4_reg;
                div_den = c4_reg;
            end
        endcase
    end

    bdm_div #(
        .DEN_W (DEN_W),
        .Q_W   (Q_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.iou_latch) begin
            iou_q_reg <= div_quo;
        end
    end

    always_comb begin
        score = $signed({1'b0, iou_q_reg}) - $signed({1'b0, div_quo});
        take  = !uni_zero_reg && (score > MINUS_ONE) && (score > kept_score_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_valid_reg <= 1'b0;
            kept_score_reg <= MINUS_ONE;
        end else if (cmd.emit) begin
            kept_valid_reg <= 1'b0;
            kept_score_reg <= MINUS_ONE;
        end else if (cmd.update && take) begin
            kept_valid_reg <= 1'b1;
            kept_score_reg <= score;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && take) begin
            kept_x_reg <= cand_x_reg;
            kept_y_reg <= cand_y_reg;
            kept_w_reg <= cand_w_reg;
            kept_h_reg <= cand_h_reg;
        end
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_found_reg      <= kept_valid_reg;
            m_best_x_reg     <= kept_valid_reg ? kept_x_reg : '0;
            m_best_y_reg     <= kept_valid_reg ? kept_y_reg : '0;
            m_best_w_reg     <= kept_valid_reg ? kept_w_reg : '0;
            m_best_h_reg     <= kept_valid_reg ? kept_h_reg : '0;
            m_best_score_reg <= kept_valid_reg ? kept_score_reg : '0;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.last     = last_reg;

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_best_x     = m_best_x_reg;
    assign m_best_y     = m_best_y_reg;
    assign m_best_w     = m_best_w_reg;
    assign m_best_h     = m_best_h_reg;
    assign m_best_score = m_best_score_reg;

endmodule

@@ rtl/best_diou_box_match_core.sv @@
// ----------------------------------------------------------------------------
// best_diou_box_match_core
// Scores candidate boxes against a reference box by Distance-IoU and reports
// the best box of each frame on the frame's last word.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake       Contents
// s_        in         s_valid/s_ready cand_x, cand_y, cand_w, cand_h, last_cand
// m_        out        m_valid/m_ready found, best_x/y/w/h, best_score
// APB       in         psel/penable    ref_x, ref_y, ref_w, ref_h at 0x0..0xC
//
// A new word is accepted only after the previous one has been scored, as
// the two divisions share one divider at one quotient bit a cycle.
// On a frame's last word an emit state then loads the result register.
// A new word is accepted while a result waits; only the next frame end stalls
// until the previous result is taken. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module best_diou_box_match_core
    import bdm_pkg::*;
#(
    parameter int unsigned COORD_BITS = 13,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_cand_x,
    input  logic signed [COORD_BITS-1:0]  s_cand_y,
    input  logic        [COORD_BITS-2:0]  s_cand_w,
    input  logic        [COORD_BITS-2:0]  s_cand_h,
    input  logic                          s_last_cand,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic signed [COORD_BITS-1:0]  m_best_x,
    output logic signed [COORD_BITS-1:0]  m_best_y,
    output logic        [COORD_BITS-2:0]  m_best_w,
    output logic        [COORD_BITS-2:0]  m_best_h,
    output logic signed [FRAC_BITS+1:0]   m_best_score
);

    localparam int unsigned C_W = COORD_BITS;
    localparam int unsigned S_W = COORD_BITS - 1;

    logic [C_W-1:0] ref_x_reg, ref_y_reg;
    logic [S_W-1:0] ref_w_reg, ref_h_reg;
    logic           wr_en;
    bdm_cmd_t       cmd;
    bdm_status_t    status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_w_reg <= '0;
            ref_h_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_REF_X: ref_x_reg <= pwdata[C_W-1:0];
                REG_REF_Y: ref_y_reg <= pwdata[C_W-1:0];
                REG_REF_W: ref_w_reg <= pwdata[S_W-1:0];
                REG_REF_H: ref_h_reg <= pwdata[S_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_REF_X: prdata = 32'(ref_x_reg);
            REG_REF_Y: prdata = 32'(ref_y_reg);
            REG_REF_W: prdata = 32'(ref_w_reg);
            REG_REF_H: prdata = 32'(ref_h_reg);
            default:   prdata = '0;
        endcase
    end

    bdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bdm_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_cand_x     (s_cand_x),
        .s_cand_y     (s_cand_y),
        .s_cand_w     (s_cand_w),
        .s_cand_h     (s_cand_h),
        .s_last_cand  (s_last_cand),
        .ref_x        ($signed(ref_x_reg)),
        .ref_y        ($signed(ref_y_reg)),
        .ref_w        (ref_w_reg),
        .ref_h        (ref_h_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_best_x     (m_best_x),
        .m_best_y     (m_best_y),
        .m_best_w     (m_best_w),
        .m_best_h     (m_best_h),
        .m_best_score (m_best_score)
    );

endmodule

@@ bench/best_diou_box_match_core_tb.sv @@
// ----------------------------------------------------------------------------
// best_diou_box_match_core_tb
// Streams candidate boxes into the core and checks each frame's best match.
// A local Distance-IoU scorer tracks the kept box per frame. The run covers
// reset-state frames, directed frames, extreme reference boxes, random
// frames under several handshake idling patterns, and a long result stall.
// ----------------------------------------------------------------------------
module best_diou_box_match_core_tb
    import bdm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 13;
    localparam int FB = 16;
    localparam longint ONE_Q = longint'(1) << FB;
    localparam int SETTLE_CYCLES = 2 * FB + 11 + 8;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic [CB-2:0] span_t;

    typedef struct {
        logic                found;
        coord_t              x;
        coord_t              y;
        span_t               w;
        span_t               h;
        logic signed [FB+1:0] score;
    } match_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_cand_x = '0;
    coord_t s_cand_y = '0;
    span_t s_cand_w = '0;
    span_t s_cand_h = '0;
    logic s_last_cand = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    coord_t m_best_x;
    coord_t m_best_y;
    span_t m_best_w;
    span_t m_best_h;
    logic signed [FB+1:0] m_best_score;

    coord_t ref_x_cfg = '0;
    coord_t ref_y_cfg = '0;
    span_t ref_w_cfg = '0;
    span_t ref_h_cfg = '0;

    longint kept_score = -ONE_Q;
    match_t kept_box = '{1'b0, '0, '0, '0, '0, '0};
    match_t expected_matches[$];

    coord_t prev_x = '0;
    coord_t prev_y = '0;
    span_t prev_w = '0;
    span_t prev_h = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int n_boxes = 0;
    int n_frames = 0;
    int n_empty = 0;
    int n_skipped = 0;
    int n_checked = 0;

    best_diou_box_match_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cand_x     (s_cand_x),
        .s_cand_y     (s_cand_y),
        .s_cand_w     (s_cand_w),
        .s_cand_h     (s_cand_h),
        .s_last_cand  (s_last_cand),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_best_x     (m_best_x),
        .m_best_y     (m_best_y),
        .m_best_w     (m_best_w),
        .m_best_h     (m_best_h),
        .m_best_score (m_best_score)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("best_diou_box_match_core_tb: errors");
        $finish;
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic bit diou_q16(input coord_t x, input coord_t y, input span_t w,
                                    input span_t h, output longint score);
        longint cx, cy, cw, ch, rx, ry, rw, rh;
        longint r1, b1, r2, b2, iw, ih, inter, uni, ew, eh, dx, dy, c4, d4;
        cx = x;
        cy = y;
        cw = w;
        ch = h;
        rx = ref_x_cfg;
        ry = ref_y_cfg;
        rw = ref_w_cfg;
        rh = ref_h_cfg;
        r1 = cx + cw;
        b1 = cy + ch;
        r2 = rx + rw;
        b2 = ry + rh;
        iw = ((r1 < r2) ? r1 : r2) - ((cx > rx) ? cx : rx);
        ih = ((b1 < b2) ? b1 : b2) - ((cy > ry) ? cy : ry);
        inter = (iw > 0 && ih > 0) ? iw * ih : 0;
        uni = cw * ch + rw * rh - inter;
        ew = ((r1 > r2) ? r1 : r2) - ((cx < rx) ? cx : rx);
        eh = ((b1 > b2) ? b1 : b2) - ((cy < ry) ? cy : ry);
        dx = (2 * cx + cw) - (2 * rx + rw);
        dy = (2 * cy + ch) - (2 * ry + rh);
        score = 0;
        if (uni <= 0) begin
            return 1'b0;
        end
        c4 = 4 * (ew * ew + eh * eh);
        if (c4 == 0) begin
            return 1'b0;
        end
        d4 = dx * dx + dy * dy;
        score = ((inter << FB) / uni) - ((d4 << FB) / c4);
        return 1'b1;
    endfunction

    task automatic send_box(input coord_t x, input coord_t y, input span_t w,
                            input span_t h, input bit last);
        longint score;
        bit scored;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cand_x <= x;
        s_cand_y <= y;
        s_cand_w <= w;
        s_cand_h <= h;
        s_last_cand <= last;
        do @(posedge aclk); while (!s_ready);
        n_boxes++;
        scored = diou_q16(x, y, w, h, score);
        if (!scored) begin
            n_skipped++;
        end else if (score > -ONE_Q && score > kept_score) begin
            kept_score = score;
            kept_box = '{1'b1, x, y, w, h, score[FB+1:0]};
        end
        if (last) begin
            expected_matches.insert(expected_matches.size(), kept_box);
            n_frames++;
            if (!kept_box.found) begin
                n_empty++;
            end
            kept_score = -ONE_Q;
            kept_box = '{1'b0, '0, '0, '0, '0, '0};
        end
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (expected_matches.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value,
                                  input int bits);
        logic [31:0] mask;
        logic [31:0] back;
        mask = (32'd1 << bits) - 32'd1;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom() << bits) | (value & mask);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        apb_read(idx, back);
        if ((back & mask) !== (value & mask)) begin
            note_error($sformatf("register %0d read back %h, wrote %h", idx,
                                 back & mask, value & mask));
        end
    endtask

    task automatic set_reference(input coord_t x, input coord_t y, input span_t w,
                                 input span_t h);
        wait_quiet();
        write_register(REG_REF_X, 32'(unsigned'(x)), CB);
        write_register(REG_REF_Y, 32'(unsigned'(y)), CB);
        write_register(REG_REF_W, 32'(w), CB - 1);
        write_register(REG_REF_H, 32'(h), CB - 1);
        ref_x_cfg = x;
        ref_y_cfg = y;
        ref_w_cfg = w;
        ref_h_cfg = h;
    endtask

    function automatic coord_t clamp_coord(input longint v);
        if (v < -4096) begin
            return coord_t'(-4096);
        end
        if (v > 4095) begin
            return coord_t'(4095);
        end
        return coord_t'(v);
    endfunction

    function automatic span_t clamp_span(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 4095) begin
            return span_t'(4095);
        end
        return span_t'(v);
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    task automatic pick_box(output coord_t x, output coord_t y, output span_t w,
                            output span_t h);
        int pick;
        longint span;
        pick = $urandom_range(99);
        span = (longint'(ref_w_cfg) + longint'(ref_h_cfg)) / 2 + 8;
        if (pick < 55) begin
            x = clamp_coord(longint'(ref_x_cfg) + jitter(span));
            y = clamp_coord(longint'(ref_y_cfg) + jitter(span));
            w = clamp_span(longint'(ref_w_cfg) + jitter(span / 2));
            h = clamp_span(longint'(ref_h_cfg) + jitter(span / 2));
        end else if (pick < 70) begin
            x = coord_t'($urandom());
            y = coord_t'($urandom());
            w = span_t'($urandom());
            h = span_t'($urandom());
        end else if (pick < 80) begin
            x = clamp_coord(longint'(ref_x_cfg) + jitter(span));
            y = clamp_coord(longint'(ref_y_cfg) + jitter(span));
            w = ($urandom_range(1) == 0) ? span_t'(0) : span_t'($urandom_range(64));
            h = (w != 0) ? span_t'(0) : span_t'($urandom_range(64));
        end else if (pick < 90) begin
            x = clamp_coord(longint'(ref_x_cfg) + jitter(span));
            y = clamp_coord(longint'(ref_y_cfg) + jitter(span));
            w = span_t'($urandom_range(64));
            h = span_t'($urandom_range(64));
        end else begin
            x = prev_x;
            y = prev_y;
            w = prev_w;
            h = prev_h;
        end
        prev_x = x;
        prev_y = y;
        prev_w = w;
        prev_h = h;
    endtask

    task automatic run_frames(input int n_items);
        int sent;
        int len;
        coord_t x, y;
        span_t w, h;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(99) < 10) ? $urandom_range(30, 10) : $urandom_range(6, 1);
            if (len > n_items - sent) begin
                len = n_items - sent;
            end
            for (int i = 0; i < len; i++) begin
                pick_box(x, y, w, h);
                send_box(x, y, w, h, i == len - 1);
            end
            sent += len;
            if ($urandom_range(99) < 4) begin
                wait_quiet();
            end
        end
    endtask

    task automatic test_reset_state();
        logic [31:0] back;
        for (int i = 0; i < 4; i++) begin
            apb_read(i[1:0], back);
            if (back !== 32'd0) begin
                note_error($sformatf("register %0d reads %h after reset", i, back));
            end
        end
        send_box(13'sd5, 13'sd5, 12'd0, 12'd7, 1'b1);
        send_box(13'sd0, 13'sd0, 12'd0, 12'd0, 1'b0);
        send_box(13'sd0, 13'sd0, 12'd10, 12'd10, 1'b1);
    endtask

    task automatic test_directed_frames();
        set_reference(13'sd0, 13'sd0, 12'd100, 12'd100);
        send_box(13'sd10, 13'sd0, 12'd100, 12'd100, 1'b0);
        send_box(-13'sd10, 13'sd0, 12'd100, 12'd100, 1'b1);
        send_box(13'sd0, 13'sd0, 12'd100, 12'd100, 1'b1);
        send_box(-13'sd4096, -13'sd4096, 12'd4095, 12'd4095, 1'b0);
        send_box(13'sd4095, 13'sd4095, 12'd4095, 12'd4095, 1'b0);
        send_box(-13'sd4096, 13'sd4095, 12'd0, 12'd4095, 1'b0);
        send_box(13'sd4095, -13'sd4096, 12'd4095, 12'd0, 1'b1);
        send_box(13'sd2000, 13'sd2000, 12'd10, 12'd10, 1'b0);
        send_box(13'sd50, 13'sd50, 12'd10, 12'd10, 1'b1);
        send_box(13'sd25, 13'sd25, 12'd50, 12'd50, 1'b1);
        send_box(13'sd0, 13'sd0, 12'd100, 12'd90, 1'b0);
        send_box(13'sd3000, -13'sd3000, 12'd5, 12'd5, 1'b1);
    endtask

    task automatic test_reference_extremes();
        set_reference(-13'sd4096, -13'sd4096, 12'd4095, 12'd4095);
        run_frames(80);
        set_reference(13'sd4095, 13'sd4095, 12'd4095, 12'd4095);
        run_frames(80);
        set_reference(13'sd4095, -13'sd4096, 12'd0, 12'd0);
        run_frames(60);
    endtask

    task automatic test_random_traffic();
        int send_pct[4] = '{0, 54, 0, 35};
        int recv_pct[4] = '{0, 0, 54, 35};
        for (int mode = 0; mode < 4; mode++) begin
            for (int k = 0; k < 2; k++) begin
                set_reference(coord_t'($urandom()), coord_t'($urandom()),
                              span_t'($urandom_range(($urandom_range(1) == 0) ? 200 : 4095)),
                              span_t'($urandom_range(($urandom_range(1) == 0) ? 200 : 4095)));
                send_idle_pct = send_pct[mode];
                recv_stall_pct = recv_pct[mode];
                run_frames(150);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_result_backpressure();
        coord_t x, y;
        span_t w, h;
        set_reference(13'sd100, -13'sd200, 12'd300, 12'd150);
        hold_left = 600;
        for (int i = 0; i < 30; i++) begin
            pick_box(x, y, w, h);
            send_box(x, y, w, h, i[0]);
        end
        wait_quiet();
    endtask

    always @(posedge aclk) begin : result_check
        match_t exp;
        string diffs;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                note_error("result word arrived with no frame pending");
            end else begin
                exp = expected_matches.pop_front();
                n_checked++;
                diffs = "";
                if (m_found !== exp.found) begin
                    diffs = {diffs, $sformatf(" found %0d/%0d", exp.found, m_found)};
                end
                if (m_best_x !== exp.x) begin
                    diffs = {diffs, $sformatf(" x %0d/%0d", exp.x, m_best_x)};
                end
                if (m_best_y !== exp.y) begin
                    diffs = {diffs, $sformatf(" y %0d/%0d", exp.y, m_best_y)};
                end
                if (m_best_w !== exp.w) begin
                    diffs = {diffs, $sformatf(" w %0d/%0d", exp.w, m_best_w)};
                end
                if (m_best_h !== exp.h) begin
                    diffs = {diffs, $sformatf(" h %0d/%0d", exp.h, m_best_h)};
                end
                if (m_best_score !== exp.score) begin
                    diffs = {diffs, $sformatf(" score %0d/%0d", exp.score, m_best_score)};
                end
                if (diffs != "") begin
                    note_error($sformatf("result %0d mismatch (expected/actual):%s",
                                         n_checked, diffs));
                end
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_frames();
        test_reference_extremes();
        test_random_traffic();
        test_result_backpressure();
        wait_quiet();
        if (expected_matches.size() != 0) begin
            note_error("frames still waiting for a result at the end");
        end
        $display("Scored %0d boxes over %0d frames (%0d without a match, %0d empty unions).",
                 n_boxes, n_frames, n_empty, n_skipped);
        $display("Checked %0d result words under idle, stall and long hold-off traffic.",
                 n_checked);
        if (error_count == 0) begin
            $display("best_diou_box_match_core_tb: clean");
        end else begin
            $display("best_diou_box_match_core_tb: errors");
        end
        $finish;
    end

endmodule
